[src/assert_macros.svh]
// Assertion macros shared by the price level matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop at every rising edge of clk while rstn is high.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check prop at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[src/plm_pkg.sv]
// Package with widths, result codes and controller/datapath interface types.
package plm_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;

    localparam int ID_W       = 32;
    localparam int VOL_W      = 32;
    localparam int PRICE_W    = 32;
    localparam int TOTAL_W    = 38;
    localparam int RES_KIND_W = 2;

    localparam logic [RES_KIND_W-1:0] RES_ADD_OK   = 2'd0;
    localparam logic [RES_KIND_W-1:0] RES_ADD_FULL = 2'd1;
    localparam logic [RES_KIND_W-1:0] RES_FILL     = 2'd2;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_MATCH = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;

    typedef struct packed {
        logic accept;
        logic add_go;
        logic fill_go;
    } plm_cmd_t;

    typedef struct packed {
        logic new_match;
        logic empty;
        logic out_free;
        logic fill_last;
    } plm_status_t;

endpackage

[src/price_level_fifo_matcher_core.sv]
// Top level of the price level matcher: one order book level with a FIFO of resting orders.
//
// Input channel s_*: one beat is an add (s_kind 0) or a match (s_kind 1) item, taken
// when s_valid and s_ready are both high. s_ready is high only while no item is in work.
// Result channel m_*: beats held in an output register until m_ready; m_last marks the
// final beat of an item. A match on an empty level gives no beat.
// After acceptance an add waits in the add state until the output register is free, then
// loads its ack or rejection beat there and returns to idle.
// A match reads the front order at acceptance, then issues its fills one after another,
// each once the output register is free; the queue RAM read is registered and the next
// front is read while the current fill is written back.
// If m_ready stays low, the fill sequence holds in place; nothing is dropped.
// The user writes level_price through cfg_wr_en/cfg_wr_data while the block is idle; the
// block does not enforce this. Reset (aresetn low, synchronous) empties the level, clears
// the total and the price, and drops any pending result beat. The queue RAM is not cleared.
module price_level_fifo_matcher_core #(
    parameter int QUEUE_DEPTH = plm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic                                s_side,
    input  logic [plm_pkg::ID_W-1:0]            s_order_ident,
    input  logic [plm_pkg::ID_W-1:0]            s_user_ident,
    input  logic [plm_pkg::VOL_W-1:0]           s_order_volume,
    input  logic [plm_pkg::ID_W-1:0]            s_symbol_code,
    input  logic                                cfg_wr_en,
    input  logic [plm_pkg::PRICE_W-1:0]         cfg_wr_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [plm_pkg::RES_KIND_W-1:0]      m_result_kind,
    output logic [plm_pkg::ID_W-1:0]            m_buyer_order,
    output logic [plm_pkg::ID_W-1:0]            m_seller_order,
    output logic [plm_pkg::ID_W-1:0]            m_buyer_user,
    output logic [plm_pkg::ID_W-1:0]            m_seller_user,
    output logic [plm_pkg::VOL_W-1:0]           m_fill_volume,
    output logic signed [plm_pkg::PRICE_W-1:0]  m_trade_price,
    output logic [plm_pkg::ID_W-1:0]            m_trade_symbol,
    output logic [plm_pkg::VOL_W-1:0]           m_incoming_left,
    output logic [plm_pkg::TOTAL_W-1:0]         m_level_total,
    output logic                                m_last
);

    import plm_pkg::*;

    plm_cmd_t    cmd;
    plm_status_t status;

    plm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    plm_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_kind          (s_kind),
        .s_side          (s_side),
        .s_order_ident   (s_order_ident),
        .s_user_ident    (s_user_ident),
        .s_order_volume  (s_order_volume),
        .s_symbol_code   (s_symbol_code),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_buyer_order   (m_buyer_order),
        .m_seller_order  (m_seller_order),
        .m_buyer_user    (m_buyer_user),
        .m_seller_user   (m_seller_user),
        .m_fill_volume   (m_fill_volume),
        .m_trade_price   (m_trade_price),
        .m_trade_symbol  (m_trade_symbol),
        .m_incoming_left (m_incoming_left),
        .m_level_total   (m_level_total),
        .m_last          (m_last)
    );

endmodule

[src/plm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module plm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/plm_datapath.sv]
// Datapath: resting order queue, level state, fill arithmetic and result register.
`include "assert_macros.svh"

module plm_datapath #(
    parameter int QUEUE_DEPTH = plm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  plm_pkg::plm_cmd_t                   cmd,
    output plm_pkg::plm_status_t                status,
    input  logic                                s_kind,
    input  logic                                s_side,
    input  logic [plm_pkg::ID_W-1:0]            s_order_ident,
    input  logic [plm_pkg::ID_W-1:0]            s_user_ident,
    input  logic [plm_pkg::VOL_W-1:0]           s_order_volume,
    input  logic [plm_pkg::ID_W-1:0]            s_symbol_code,
    input  logic                                cfg_wr_en,
    input  logic [plm_pkg::PRICE_W-1:0]         cfg_wr_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [plm_pkg::RES_KIND_W-1:0]      m_result_kind,
    output logic [plm_pkg::ID_W-1:0]            m_buyer_order,
    output logic [plm_pkg::ID_W-1:0]            m_seller_order,
    output logic [plm_pkg::ID_W-1:0]            m_buyer_user,
    output logic [plm_pkg::ID_W-1:0]            m_seller_user,
    output logic [plm_pkg::VOL_W-1:0]           m_fill_volume,
    output logic signed [plm_pkg::PRICE_W-1:0]  m_trade_price,
    output logic [plm_pkg::ID_W-1:0]            m_trade_symbol,
    output logic [plm_pkg::VOL_W-1:0]           m_incoming_left,
    output logic [plm_pkg::TOTAL_W-1:0]         m_level_total,
    output logic                                m_last
);

    import plm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = 2 * ID_W + VOL_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    logic [PTR_W-1:0]   head_reg, head_next, tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [TOTAL_W-1:0] total_reg, total_add, total_sub;
    logic [PRICE_W-1:0] price_reg;

    logic               side_reg;
    logic [ID_W-1:0]    oid_reg, uid_reg, sym_reg;
    logic [VOL_W-1:0]   vol_reg;

    logic                  m_valid_reg;
    logic [RES_KIND_W-1:0] res_kind_reg;
    logic [ID_W-1:0]       buyer_order_reg, seller_order_reg;
    logic [ID_W-1:0]       buyer_user_reg, seller_user_reg, symbol_reg;
    logic [VOL_W-1:0]      fill_volume_reg, incoming_left_reg;
    logic [PRICE_W-1:0]    price_out_reg;
    logic [TOTAL_W-1:0]    level_total_reg;
    logic                  last_reg;

    logic               ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]   ram_wr_addr;
    logic [ENT_W-1:0]   ram_wr_data, ram_rd_data;

    logic [ID_W-1:0]    rest_oid, rest_uid;
    logic [VOL_W-1:0]   rest_vol, fill_vol, inc_left, rest_left;
    logic               popped, full, empty, out_free, fill_last;

    assign rest_oid  = ram_rd_data[ENT_W-1 -: ID_W];
    assign rest_uid  = ram_rd_data[VOL_W +: ID_W];
    assign rest_vol  = ram_rd_data[VOL_W-1:0];
    assign fill_vol  = (vol_reg < rest_vol) ? vol_reg : rest_vol;
    assign inc_left  = vol_reg - fill_vol;
    assign rest_left = rest_vol - fill_vol;
    assign popped    = (rest_left == '0);
    assign full      = (count_reg == DEPTH_CNT);
    assign empty     = (count_reg == '0);
    assign out_free  = !m_valid_reg || m_ready;
    assign fill_last = (inc_left == '0) || (popped && count_reg == ONE_CNT);
    assign total_add = total_reg + TOTAL_W'(vol_reg);
    assign total_sub = total_reg - TOTAL_W'(fill_vol);
    assign head_next = (cmd.fill_go && popped) ? next_slot(head_reg) : head_reg;

    assign status.new_match = (s_kind == KIND_MATCH);
    assign status.empty     = empty;
    assign status.out_free  = out_free;
    assign status.fill_last = fill_last;

    assign ram_wr_en   = (cmd.add_go && !full) || cmd.fill_go;
    assign ram_wr_addr = cmd.fill_go ? head_reg : tail_reg;
    assign ram_wr_data = cmd.fill_go ? {rest_oid, rest_uid, rest_left}
                                     : {oid_reg, uid_reg, vol_reg};
    assign ram_rd_en   = cmd.accept || cmd.fill_go;

    plm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_rest_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (head_next),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            price_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                price_reg <= cfg_wr_data;
            end
            if (cmd.add_go && !full) begin
                tail_reg  <= next_slot(tail_reg);
                count_reg <= count_reg + ONE_CNT;
                total_reg <= total_add;
            end
            if (cmd.fill_go) begin
                head_reg  <= head_next;
                total_reg <= total_sub;
                if (popped) begin
                    count_reg <= count_reg - ONE_CNT;
                end
            end
            if (cmd.add_go || cmd.fill_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            side_reg <= s_side;
            oid_reg  <= s_order_ident;
            uid_reg  <= s_user_ident;
            vol_reg  <= s_order_volume;
            sym_reg  <= s_symbol_code;
        end else if (cmd.fill_go) begin
            vol_reg  <= inc_left;
        end
        if (cmd.add_go) begin
            res_kind_reg      <= full ? RES_ADD_FULL : RES_ADD_OK;
            buyer_order_reg   <= '0;
            seller_order_reg  <= '0;
            buyer_user_reg    <= '0;
            seller_user_reg   <= '0;
            fill_volume_reg   <= '0;
            price_out_reg     <= '0;
            symbol_reg        <= '0;
            incoming_left_reg <= '0;
            level_total_reg   <= full ? total_reg : total_add;
            last_reg          <= 1'b1;
        end else if (cmd.fill_go) begin
            res_kind_reg      <= RES_FILL;
            if (side_reg == SIDE_BUY) begin
                buyer_order_reg  <= oid_reg;
                seller_order_reg <= rest_oid;
                buyer_user_reg   <= uid_reg;
                seller_user_reg  <= rest_uid;
            end else begin
                buyer_order_reg  <= rest_oid;
                seller_order_reg <= oid_reg;
                buyer_user_reg   <= rest_uid;
                seller_user_reg  <= uid_reg;
            end
            fill_volume_reg   <= fill_vol;
            price_out_reg     <= price_reg;
            symbol_reg        <= sym_reg;
            incoming_left_reg <= inc_left;
            level_total_reg   <= total_sub;
            last_reg          <= fill_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = res_kind_reg;
    assign m_buyer_order   = buyer_order_reg;
    assign m_seller_order  = seller_order_reg;
    assign m_buyer_user    = buyer_user_reg;
    assign m_seller_user   = seller_user_reg;
    assign m_fill_volume   = fill_volume_reg;
    assign m_trade_price   = signed'(price_out_reg);
    assign m_trade_symbol  = symbol_reg;
    assign m_incoming_left = incoming_left_reg;
    assign m_level_total   = level_total_reg;
    assign m_last          = last_reg;

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= DEPTH_CNT, "entry count above depth")
    `ASSERT_CLK(a_ptr_match, aclk, aresetn, (head_reg == tail_reg) == (empty || full), "head/tail disagree with count")
    `ASSERT_CLK(a_partial_is_last, aclk, aresetn, (cmd.fill_go && !popped) |-> fill_last, "partial fill not last")

endmodule

[src/plm_ctrl.sv]
// Controller: sequences add and match items over the datapath.
`include "assert_macros.svh"

module plm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  plm_pkg::plm_status_t status,
    output plm_pkg::plm_cmd_t    cmd
);

    import plm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ADD  = 3'b010,
        ST_FILL = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.add_go  = 1'b0;
        cmd.fill_go = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!status.new_match) begin
                        state_next = ST_ADD;
                    end else if (!status.empty) begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_ADD: begin
                if (status.out_free) begin
                    cmd.add_go = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FILL: begin
                if (status.out_free) begin
                    cmd.fill_go = 1'b1;
                    if (status.fill_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    `ASSERT_CLK(a_go_needs_room, aclk, aresetn, (cmd.add_go || cmd.fill_go) |-> status.out_free, "result issued into busy output")
    `ASSERT_CLK(a_fill_stays, aclk, aresetn, (state_reg == ST_FILL && !status.out_free) |=> (state_reg == ST_FILL), "match left while stalled")
    `ASSERT_CLK(a_state_onehot, aclk, aresetn, $onehot(state_reg), "state not one-hot")

endmodule
